/* hdl/dfcf_pkg.sv */
// Shared types, opcodes and helper functions of the DataFlash command framer.
// No dependencies; every other file in hdl/ refers to this package by scoped names.

package dfcf_pkg;

  // Register reset values and limits.
  localparam logic [3:0]  BYTE_ADDR_BITS_RST = 4'd10;
  localparam logic [11:0] BUFFER_SIZE_RST    = 12'd528;
  localparam logic [11:0] FILL_MAX           = 12'd4095;
  localparam int unsigned PAGE_COUNT         = 8192;
  localparam int unsigned QUEUE_DEPTH        = 2;

  // Register map, word index taken from paddr[2].
  typedef enum logic [0:0] {
    REG_BYTE_ADDR_BITS = 1'b0,
    REG_BUFFER_SIZE    = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    OP_WR_VIA_BUF  = 4'd0,
    OP_WR_BUF      = 4'd1,
    OP_BUF2PAGE    = 4'd2,
    OP_READ_PAGE   = 4'd3,
    OP_PAGE2BUF    = 4'd4,
    OP_ERASE_PAGE  = 4'd5,
    OP_ERASE_BLOCK = 4'd6,
    OP_ERASE_SECT  = 4'd7,
    OP_ERASE_CHIP  = 4'd8,
    OP_STATUS      = 4'd9,
    OP_ID          = 4'd10,
    OP_SLEEP       = 4'd11,
    OP_RESUME      = 4'd12,
    OP_LOG_SAVE    = 4'd13,
    OP_SYNC        = 4'd14,
    OP_ZERO_INDEX  = 4'd15
  } op_e;

  // Flash opcodes.
  localparam logic [7:0] OPC_WR_VIA_BUF1 = 8'h82;
  localparam logic [7:0] OPC_WR_VIA_BUF2 = 8'h85;
  localparam logic [7:0] OPC_WR_BUF1     = 8'h84;
  localparam logic [7:0] OPC_WR_BUF2     = 8'h87;
  localparam logic [7:0] OPC_BUF1_PAGE   = 8'h88;
  localparam logic [7:0] OPC_BUF2_PAGE   = 8'h89;
  localparam logic [7:0] OPC_READ_PAGE   = 8'hD2;
  localparam logic [7:0] OPC_PAGE_BUF1   = 8'h53;
  localparam logic [7:0] OPC_PAGE_BUF2   = 8'h55;
  localparam logic [7:0] OPC_ERASE_PAGE  = 8'h81;
  localparam logic [7:0] OPC_ERASE_BLOCK = 8'h50;
  localparam logic [7:0] OPC_ERASE_SECT  = 8'h7C;
  localparam logic [7:0] OPC_CHIP_0      = 8'hC7;
  localparam logic [7:0] OPC_CHIP_1      = 8'h94;
  localparam logic [7:0] OPC_CHIP_2      = 8'h80;
  localparam logic [7:0] OPC_CHIP_3      = 8'h9A;
  localparam logic [7:0] OPC_STATUS      = 8'hD7;
  localparam logic [7:0] OPC_ID          = 8'h9F;
  localparam logic [7:0] OPC_SLEEP       = 8'hB9;
  localparam logic [7:0] OPC_RESUME      = 8'hAB;

  localparam logic [11:0] STATUS_READ_LEN = 12'd1;
  localparam logic [11:0] ID_READ_LEN     = 12'd4;

  typedef struct packed {
    logic [3:0]  op;
    logic [12:0] page;
    logic [10:0] byte_offset;
    logic        buffer_sel;
    logic [11:0] length;
  } req_t;

  typedef struct packed {
    logic [7:0]  spi_byte;
    logic        last;
    logic [11:0] write_len;
    logic [11:0] read_len;
  } res_t;

  // One request's worth of frame bytes, byte 0 goes out first.
  typedef struct packed {
    logic [7:0][7:0] bytes;
    logic [3:0]      num_bytes;  // 1..8
    logic            mid_last;   // byte 3 also closes a frame
    logic [11:0]     write_len;
    logic [11:0]     read_len;
  } desc_t;

  // Flash address of a page: page above the byte-offset bits, plus offset, 24 bits.
  function automatic logic [23:0] page_addr_f(logic [12:0] page, logic [10:0] off,
                                              logic [3:0] bits);
    logic [23:0] base;
    if (bits <= 4'd9) begin
      base = {2'b00, page, 9'd0};
    end else if (bits == 4'd10) begin
      base = {1'b0, page, 10'd0};
    end else begin
      base = {page, 11'd0};
    end
    return base + {13'd0, off};
  endfunction

  // Opcode then address, high byte first.
  function automatic logic [3:0][7:0] frame_f(logic [7:0] opc, logic [23:0] addr);
    logic [3:0][7:0] f;
    f[0] = opc;
    f[1] = addr[23:16];
    f[2] = addr[15:8];
    f[3] = addr[7:0];
    return f;
  endfunction

endpackage

/* hdl/dfcf_front.sv */
// Front end: classifies each request, builds its frame descriptor and keeps log-save state.
// Depends on dfcf_pkg.

module dfcf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  dfcf_pkg::req_t    req_i,
  input  logic [3:0]        byte_addr_bits_i,
  input  logic [11:0]       buf_bytes_i,
  output logic              desc_push_o,
  output dfcf_pkg::desc_t   desc_o
);

  logic        active_buf_q, active_buf_d;
  logic [11:0] fill_q, fill_d;
  logic [12:0] log_page_q, log_page_d;

  logic [12:0] save_sum;
  logic        save_ovf;
  logic        save_sync;
  logic        save_buf;
  logic [11:0] save_fill;
  logic [12:0] save_new;
  logic [12:0] log_page_inc;
  logic [23:0] req_addr;
  logic [23:0] req_page_addr;
  logic [23:0] log_addr;
  logic [7:0]  sync_opc;

  assign req_addr      = dfcf_pkg::page_addr_f(req_i.page, req_i.byte_offset, byte_addr_bits_i);
  assign req_page_addr = dfcf_pkg::page_addr_f(req_i.page, 11'd0, byte_addr_bits_i);
  assign log_addr      = dfcf_pkg::page_addr_f(log_page_q, 11'd0, byte_addr_bits_i);
  assign sync_opc      = active_buf_q ? dfcf_pkg::OPC_BUF1_PAGE : dfcf_pkg::OPC_BUF2_PAGE;

  // Wrap the log page at the device size.
  assign log_page_inc = (log_page_q == 13'(dfcf_pkg::PAGE_COUNT - 1)) ? 13'd0
                                                                       : log_page_q + 13'd1;

  // Log-save: flush first when the data would overrun a buffer that already holds data.
  assign save_sum  = {1'b0, fill_q} + {1'b0, req_i.length};
  assign save_ovf  = save_sum > {1'b0, buf_bytes_i};
  assign save_sync = save_ovf && (fill_q != 12'd0);
  assign save_buf  = save_sync ? ~active_buf_q : active_buf_q;
  assign save_fill = save_sync ? 12'd0 : fill_q;
  assign save_new  = {1'b0, save_fill} + {1'b0, req_i.length};

  always_comb begin
    desc_o       = '0;
    active_buf_d = active_buf_q;
    fill_d       = fill_q;
    log_page_d   = log_page_q;
    case (dfcf_pkg::op_e'(req_i.op))
      dfcf_pkg::OP_WR_VIA_BUF: begin
        desc_o.bytes[3:0] = dfcf_pkg::frame_f(req_i.buffer_sel ? dfcf_pkg::OPC_WR_VIA_BUF1
                                                               : dfcf_pkg::OPC_WR_VIA_BUF2,
                                              req_addr);
        desc_o.num_bytes  = 4'd4;
        desc_o.write_len  = req_i.length;
      end
      dfcf_pkg::OP_WR_BUF: begin
        desc_o.bytes[3:0] = dfcf_pkg::frame_f(req_i.buffer_sel ? dfcf_pkg::OPC_WR_BUF1
                                                               : dfcf_pkg::OPC_WR_BUF2,
                                              {13'd0, req_i.byte_offset});
        desc_o.num_bytes  = 4'd4;
        desc_o.write_len  = req_i.length;
      end
      dfcf_pkg::OP_BUF2PAGE: begin
        desc_o.bytes[3:0] = dfcf_pkg::frame_f(req_i.buffer_sel ? dfcf_pkg::OPC_BUF1_PAGE
                                                               : dfcf_pkg::OPC_BUF2_PAGE,
                                              req_page_addr);
        desc_o.num_bytes  = 4'd4;
        fill_d            = 12'd0;
      end
      dfcf_pkg::OP_READ_PAGE: begin
        desc_o.bytes[3:0] = dfcf_pkg::frame_f(dfcf_pkg::OPC_READ_PAGE, req_addr);
        desc_o.num_bytes  = 4'd8;
        desc_o.read_len   = req_i.length;
      end
      dfcf_pkg::OP_PAGE2BUF: begin
        desc_o.bytes[3:0] = dfcf_pkg::frame_f(req_i.buffer_sel ? dfcf_pkg::OPC_PAGE_BUF1
                                                               : dfcf_pkg::OPC_PAGE_BUF2,
                                              req_page_addr);
        desc_o.num_bytes  = 4'd4;
      end
      dfcf_pkg::OP_ERASE_PAGE: begin
        desc_o.bytes[3:0] = dfcf_pkg::frame_f(dfcf_pkg::OPC_ERASE_PAGE, req_page_addr);
        desc_o.num_bytes  = 4'd4;
      end
      dfcf_pkg::OP_ERASE_BLOCK: begin
        desc_o.bytes[3:0] = dfcf_pkg::frame_f(dfcf_pkg::OPC_ERASE_BLOCK, req_page_addr);
        desc_o.num_bytes  = 4'd4;
      end
      dfcf_pkg::OP_ERASE_SECT: begin
        desc_o.bytes[3:0] = dfcf_pkg::frame_f(dfcf_pkg::OPC_ERASE_SECT, req_page_addr);
        desc_o.num_bytes  = 4'd4;
      end
      dfcf_pkg::OP_ERASE_CHIP: begin
        desc_o.bytes[0]  = dfcf_pkg::OPC_CHIP_0;
        desc_o.bytes[1]  = dfcf_pkg::OPC_CHIP_1;
        desc_o.bytes[2]  = dfcf_pkg::OPC_CHIP_2;
        desc_o.bytes[3]  = dfcf_pkg::OPC_CHIP_3;
        desc_o.num_bytes = 4'd4;
      end
      dfcf_pkg::OP_STATUS: begin
        desc_o.bytes[0]  = dfcf_pkg::OPC_STATUS;
        desc_o.num_bytes = 4'd1;
        desc_o.read_len  = dfcf_pkg::STATUS_READ_LEN;
      end
      dfcf_pkg::OP_ID: begin
        desc_o.bytes[0]  = dfcf_pkg::OPC_ID;
        desc_o.num_bytes = 4'd1;
        desc_o.read_len  = dfcf_pkg::ID_READ_LEN;
      end
      dfcf_pkg::OP_SLEEP: begin
        desc_o.bytes[0]  = dfcf_pkg::OPC_SLEEP;
        desc_o.num_bytes = 4'd1;
      end
      dfcf_pkg::OP_RESUME: begin
        desc_o.bytes[0]  = dfcf_pkg::OPC_RESUME;
        desc_o.num_bytes = 4'd1;
      end
      dfcf_pkg::OP_LOG_SAVE: begin
        if (save_sync) begin
          desc_o.bytes[3:0] = dfcf_pkg::frame_f(sync_opc, log_addr);
          desc_o.bytes[7:4] = dfcf_pkg::frame_f(save_buf ? dfcf_pkg::OPC_WR_BUF1
                                                         : dfcf_pkg::OPC_WR_BUF2,
                                                {12'd0, save_fill});
          desc_o.num_bytes  = 4'd8;
          desc_o.mid_last   = 1'b1;
          log_page_d        = log_page_inc;
        end else begin
          desc_o.bytes[3:0] = dfcf_pkg::frame_f(save_buf ? dfcf_pkg::OPC_WR_BUF1
                                                         : dfcf_pkg::OPC_WR_BUF2,
                                                {12'd0, save_fill});
          desc_o.num_bytes  = 4'd4;
        end
        desc_o.write_len = req_i.length;
        active_buf_d     = save_buf;
        fill_d           = save_new[12] ? dfcf_pkg::FILL_MAX : save_new[11:0];
      end
      dfcf_pkg::OP_SYNC: begin
        // Nothing to flush: no bytes, state kept.
        if (fill_q != 12'd0) begin
          desc_o.bytes[3:0] = dfcf_pkg::frame_f(sync_opc, log_addr);
          desc_o.num_bytes  = 4'd4;
          active_buf_d      = ~active_buf_q;
          fill_d            = 12'd0;
          log_page_d        = log_page_inc;
        end
      end
      dfcf_pkg::OP_ZERO_INDEX: begin
        active_buf_d = 1'b0;
        fill_d       = 12'd0;
        log_page_d   = 13'd0;
      end
      default: begin
        desc_o = '0;
      end
    endcase
  end

  assign desc_push_o = accept_i && (desc_o.num_bytes != 4'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_buf_q <= 1'b0;
      fill_q       <= 12'd0;
      log_page_q   <= 13'd0;
    end else if (accept_i) begin
      active_buf_q <= active_buf_d;
      fill_q       <= fill_d;
      log_page_q   <= log_page_d;
    end
  end

endmodule

/* hdl/dfcf_queue.sv */
// Descriptor queue between the front end and the byte serializer.
// Depends on dfcf_pkg for the descriptor type.

module dfcf_queue #(
  parameter int unsigned DEPTH = dfcf_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  dfcf_pkg::desc_t wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output dfcf_pkg::desc_t rdata_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  dfcf_pkg::desc_t   mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

/* hdl/dfcf_back.sv */
// Back end: walks the head descriptor one byte a cycle into the result register
// while pop takes each result. Depends on dfcf_pkg.

module dfcf_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            desc_valid_i,
  input  dfcf_pkg::desc_t desc_i,
  output logic            desc_pop_o,
  output logic            empty_o,
  input  logic            pop_i,
  output dfcf_pkg::res_t  res_o
);

  logic           out_valid_q, out_valid_d;
  dfcf_pkg::res_t res_q, res_d;
  logic [2:0]     idx_q, idx_d;
  logic           take, load, is_end;

  assign take   = pop_i && out_valid_q;
  assign load   = desc_valid_i && (!out_valid_q || take);
  assign is_end = ({1'b0, idx_q} == (desc_i.num_bytes - 4'd1));

  always_comb begin
    res_d.spi_byte  = desc_i.bytes[idx_q];
    res_d.last      = is_end || (desc_i.mid_last && (idx_q == 3'd3));
    res_d.write_len = is_end ? desc_i.write_len : 12'd0;
    res_d.read_len  = is_end ? desc_i.read_len : 12'd0;
    idx_d           = idx_q;
    out_valid_d     = out_valid_q;
    if (load) begin
      idx_d       = is_end ? 3'd0 : idx_q + 3'd1;
      out_valid_d = 1'b1;
    end else if (take) begin
      out_valid_d = 1'b0;
    end
  end

  assign desc_pop_o = load && is_end;
  assign empty_o    = !out_valid_q;
  assign res_o      = res_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 3'd0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

endmodule

/* hdl/dataflash_command_framer.sv */
// Top level of the DataFlash command framer: register port, front end, queue, serializer.
// Depends on dfcf_pkg, dfcf_front, dfcf_queue and dfcf_back.
//
//   Channel   Direction  Handshake              Transfer
//   ------------------------------------------------------------------------------
//   request   in         push / full            one flash request (req_i)
//   result    out        empty / pop            one SPI frame byte (res_o)
//   config    in/out     psel/penable/pready    one 32-bit register write or read
//
// Output: one frame byte per cycle while pop takes each result; a request has 1, 4 or 8
// frame bytes, and zero-index and an empty sync are accepted but give none.
// Reset: clear the log-save state, the queue and the result valid flag; load the
// register reset values (10 address bits, 528 bytes).
// Stalls: a withheld pop backs up the serializer, then the queue, then raises full.

module dataflash_command_framer #(
  parameter int unsigned QUEUE_DEPTH = dfcf_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  // Request side
  input  logic           push,
  output logic           full,
  input  dfcf_pkg::req_t req_i,
  // Result side
  output logic           empty,
  input  logic           pop,
  output dfcf_pkg::res_t res_o,
  // Register port
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  logic [3:0]      byte_addr_bits_q;
  logic [11:0]     buf_bytes_q;
  logic            cfg_wr;
  logic            accept;
  logic            desc_push;
  logic            desc_pop;
  logic            desc_valid;
  dfcf_pkg::desc_t desc_in;
  dfcf_pkg::desc_t desc_head;

  // Register port: pready tied high, write on the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_addr_bits_q <= dfcf_pkg::BYTE_ADDR_BITS_RST;
      buf_bytes_q      <= dfcf_pkg::BUFFER_SIZE_RST;
    end else if (cfg_wr) begin
      case (dfcf_pkg::cfg_reg_e'(paddr[2]))
        dfcf_pkg::REG_BYTE_ADDR_BITS: byte_addr_bits_q <= pwdata[3:0];
        dfcf_pkg::REG_BUFFER_SIZE:    buf_bytes_q      <= pwdata[11:0];
        default:                      byte_addr_bits_q <= byte_addr_bits_q;
      endcase
    end
  end

  always_comb begin
    case (dfcf_pkg::cfg_reg_e'(paddr[2]))
      dfcf_pkg::REG_BYTE_ADDR_BITS: prdata = {28'd0, byte_addr_bits_q};
      dfcf_pkg::REG_BUFFER_SIZE:    prdata = {20'd0, buf_bytes_q};
      default:                      prdata = 32'd0;
    endcase
  end

  // A request transfers whenever the queue has room, even one that yields no bytes.
  assign accept = push && !full;

  // Front end: classify, build the frame descriptor, advance log-save state.
  dfcf_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .req_i            (req_i),
    .byte_addr_bits_i (byte_addr_bits_q),
    .buf_bytes_i      (buf_bytes_q),
    .desc_push_o      (desc_push),
    .desc_o           (desc_in)
  );

  // Decouple the front end from the byte serializer.
  dfcf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (desc_push),
    .wdata_i (desc_in),
    .full_o  (full),
    .pop_i   (desc_pop),
    .valid_o (desc_valid),
    .rdata_o (desc_head)
  );

  // Back end: one frame byte per cycle, while pop takes them, into the result register.
  dfcf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (desc_valid),
    .desc_i       (desc_head),
    .desc_pop_o   (desc_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .res_o        (res_o)
  );

endmodule
